### hw/rtl/wwg_pkg.sv
package wwg_pkg;

	// Period limits and derived widths
	localparam int MAX_PERIOD = 1024;
	localparam int IDX_W      = $clog2(MAX_PERIOD);
	localparam int PER_W      = 11;
	localparam int STEP_W     = 9;
	localparam int SHAPE_W    = 3;
	localparam int SAMPLE_W   = 8;

	// Fraction bits of the sine phase and the full divider dividend width
	localparam int PH_W  = 24;
	localparam int DVD_W = IDX_W + PH_W;

	// Job queue depth between front and back
	localparam int QUEUE_DEPTH_DFLT = 2;

	// Register map (word index on paddr[3:2])
	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_STEP   = 2'd1;
	localparam logic [1:0] REG_SHAPE  = 2'd2;

	// Waveform shape codes
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_SAW_UP   = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_SAW_DOWN = 3'd3;
	localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd4;
	localparam logic [SHAPE_W-1:0] SHAPE_CONST    = 3'd5;

	// Register reset values
	localparam logic [PER_W-1:0]   PERIOD_RST = 11'd256;
	localparam logic [STEP_W-1:0]  STEP_RST   = 9'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_RST  = SHAPE_CONST;

	// Q30 sine polynomial coefficients
	localparam logic [30:0] SIN_C1  = 31'd1686629713;
	localparam logic [30:0] SIN_C3  = 31'd693598668;
	localparam logic [30:0] SIN_C5  = 31'd85569306;
	localparam logic [30:0] SIN_C7  = 31'd5026993;
	localparam logic [30:0] SIN_C9  = 31'd172272;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef struct packed {
		logic [PER_W-1:0]   period;
		logic [STEP_W-1:0]  step;
		logic [SHAPE_W-1:0] shape;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [PER_W-1:0]   per;
		logic [SHAPE_W-1:0] shape;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_POLY,
		BK_OUT
	} back_state_t;

endpackage

### hw/rtl/wwg_front.sv
module wwg_front import wwg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       phase_clr,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [0] tick
	input  logic       q_full,
	output logic       push,
	output job_t       push_job
);

	logic [IDX_W-1:0] phase_q;
	logic [PER_W-1:0] per_eff;
	logic [IDX_W-1:0] idx_cur;
	logic [PER_W-1:0] step_eff;
	logic [PER_W-1:0] sum;
	logic [PER_W-1:0] nxt;

	// Clamp the period into its legal range
	always_comb begin
		if (cfg.period < PER_W'(2)) begin
			per_eff = PER_W'(2);
		end else if (cfg.period > PER_W'(MAX_PERIOD)) begin
			per_eff = PER_W'(MAX_PERIOD);
		end else begin
			per_eff = cfg.period;
		end
	end

	// Index for this item, then advance by the clamped step and wrap once
	always_comb begin
		idx_cur  = (PER_W'(phase_q) >= per_eff) ? '0 : phase_q;
		step_eff = (PER_W'(cfg.step) > per_eff) ? per_eff : PER_W'(cfg.step);
		sum      = PER_W'(idx_cur) + step_eff;
		nxt      = (sum >= per_eff) ? sum - per_eff : sum;
	end

	// Accept whenever the queue has room; a zero tick is dropped
	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready && s_tdata[0];

	always_comb begin
		push_job.idx   = idx_cur;
		push_job.per   = per_eff;
		push_job.shape = cfg.shape;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (phase_clr) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= nxt[IDX_W-1:0];
		end
	end

	a_idx_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (PER_W'(push_job.idx) < push_job.per))
		else $error("job index not below its period");

	a_per_legal: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.per >= PER_W'(2) && push_job.per <= PER_W'(MAX_PERIOD)))
		else $error("job period outside clamp range");

endmodule

### hw/rtl/wwg_queue.sv
module wwg_queue import wwg_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DFLT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t q_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;
	assign q_job   = mem_q[rd_ptr_q];

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

endmodule

### hw/rtl/wwg_back.sv
module wwg_back import wwg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  job_t        q_job,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [7:0] sample, [17:8] position
);

	back_state_t      state_q;
	back_state_t      state_d;
	job_t             job_q;
	logic [PER_W-1:0] rem_q;
	logic [PH_W-1:0]  dvd_q;
	logic [4:0]       cnt_q;
	logic [2:0]       pk_q;
	logic [61:0]      prod_q;
	logic [30:0]      t2_q;
	logic             m_tvalid_q;
	logic [23:0]      m_tdata_q;

	logic             div_en;
	logic             poly_en;
	logic             load_out;
	logic             direct;
	logic [DVD_W-1:0] dividend;
	logic [PER_W:0]   trial;
	logic             qbit;
	logic [1:0]       quad;
	logic [22:0]      xq;
	logic [30:0]      t_val;
	logic [30:0]      prod_hi;
	logic [30:0]      mul_a;
	logic [30:0]      mul_b;
	logic [30:0]      s_sat;
	logic [31:0]      lvl;
	logic [39:0]      lvl255;
	logic [8:0]       tri_k;
	logic [11:0]      half_chk;
	logic [7:0]       sample;

	// Shapes that need no division
	assign direct = (q_job.shape != SHAPE_SINE) && (q_job.shape != SHAPE_SAW_UP)
		&& (q_job.shape != SHAPE_SAW_DOWN) && (q_job.shape != SHAPE_TRIANGLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_d = direct ? BK_OUT : BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == 5'd23) begin
					state_d = (job_q.shape == SHAPE_SINE) ? BK_POLY : BK_OUT;
				end
			end
			BK_POLY: begin
				if (pk_q == 3'd5) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop      = 1'b0;
		div_en   = 1'b0;
		poly_en  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: pop = q_valid;
			BK_DIV:  div_en = 1'b1;
			BK_POLY: poly_en = 1'b1;
			BK_OUT:  load_out = !m_tvalid_q || m_tready;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Dividend: 256*i, 511*i or i scaled to a 24-bit turn fraction
	always_comb begin
		case (q_job.shape)
			SHAPE_SAW_UP,
			SHAPE_SAW_DOWN: dividend = DVD_W'({q_job.idx, 8'd0});
			SHAPE_TRIANGLE: dividend = DVD_W'({q_job.idx, 9'd0}) - DVD_W'(q_job.idx);
			default:        dividend = {q_job.idx, {PH_W{1'b0}}};
		endcase
	end

	// One quotient bit per cycle
	assign trial = {rem_q, dvd_q[PH_W-1]};
	assign qbit  = (trial >= {1'b0, job_q.per});

	// Angle within the quadrant from the phase quotient
	always_comb begin
		quad    = dvd_q[PH_W-1:PH_W-2];
		xq      = quad[0] ? (23'h40_0000 - {1'b0, dvd_q[21:0]}) : {1'b0, dvd_q[21:0]};
		t_val   = {xq, 8'd0};
		prod_hi = prod_q[60:30];
	end

	// Shared multiplier operands for the Horner steps
	always_comb begin
		mul_a = t2_q;
		mul_b = SIN_C1 - prod_hi;
		case (pk_q)
			3'd0: begin
				mul_a = t_val;
				mul_b = t_val;
			end
			3'd1: begin
				mul_a = prod_hi;
				mul_b = SIN_C9;
			end
			3'd2: mul_b = SIN_C7 - prod_hi;
			3'd3: mul_b = SIN_C5 - prod_hi;
			3'd4: mul_b = SIN_C3 - prod_hi;
			3'd5: begin
				mul_a = t_val;
				mul_b = SIN_C1 - prod_hi;
			end
			default: mul_b = SIN_C1 - prod_hi;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
			rem_q <= PER_W'(dividend[DVD_W-1:PH_W]);
			dvd_q <= dividend[PH_W-1:0];
		end else if (div_en) begin
			rem_q <= qbit ? PER_W'(trial - {1'b0, job_q.per}) : trial[PER_W-1:0];
			dvd_q <= {dvd_q[PH_W-2:0], qbit};
		end
		if (poly_en) begin
			prod_q <= mul_a * mul_b;
			if (pk_q == 3'd1) begin
				t2_q <= prod_hi;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pk_q  <= '0;
		end else begin
			cnt_q <= div_en ? cnt_q + 1'b1 : '0;
			pk_q  <= poly_en ? pk_q + 1'b1 : '0;
		end
	end

	// Final sample per shape
	always_comb begin
		s_sat    = (prod_q[61:30] > {1'b0, Q30_ONE}) ? Q30_ONE : prod_q[60:30];
		lvl      = quad[1] ? ({1'b0, Q30_ONE} - {1'b0, s_sat})
		                   : ({1'b0, Q30_ONE} + {1'b0, s_sat});
		lvl255   = {lvl, 8'd0} - {8'd0, lvl};
		tri_k    = dvd_q[8:0];
		half_chk = {1'b0, job_q.idx, 1'b0} + 12'd2;
		case (job_q.shape)
			SHAPE_SQUARE:   sample = (half_chk <= {1'b0, job_q.per}) ? 8'd0 : 8'd255;
			SHAPE_SINE:     sample = lvl255[38:31];
			SHAPE_SAW_UP:   sample = dvd_q[7:0];
			SHAPE_SAW_DOWN: sample = 8'd255 - dvd_q[7:0];
			SHAPE_TRIANGLE: sample = (tri_k <= 9'd255) ? 8'(9'd255 - tri_k)
			                                           : 8'(tri_k - 9'd255);
			default:        sample = 8'd127;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {(24 - IDX_W - SAMPLE_W)'(0), job_q.idx, sample};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < job_q.per))
		else $error("divider remainder not below period");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != BK_IDLE))
		else $error("back stayed idle after taking a job");

endmodule

### hw/rtl/wavetable_waveform_generator.sv
// Waveform generator: every tick item (tick bit set) yields one result item holding an
// 8-bit sample of the selected shape and the index at which it was taken; a tick of zero
// is dropped. For square, constant and the unused shape codes the back end does no division;
// for sawtooth and triangle a restoring divider forms 256*i/P or 511*i/P, and for sine
// the same divider forms the 24-bit phase, then six steps of one shared 31x31 multiplier
// evaluate the polynomial. A two-entry job queue sits between the index front end and
// the compute back end, so ticks keep being taken while the queue has room and a sample
// is built or waits on m_tready. Registers via APB: 0x0 period_length (write clears the
// index), 0x4 index_step, 0x8 wave_shape.
module wavetable_waveform_generator import wwg_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] sample, [17:8] position
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic phase_clr;
	logic push;
	job_t push_job;
	logic q_full;
	logic q_valid;
	job_t q_job;
	logic pop;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign phase_clr = cfg_wr && (paddr[3:2] == REG_PERIOD);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period <= PERIOD_RST;
			cfg_q.step   <= STEP_RST;
			cfg_q.shape  <= SHAPE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PERIOD: cfg_q.period <= pwdata[PER_W-1:0];
				REG_STEP:   cfg_q.step   <= pwdata[STEP_W-1:0];
				REG_SHAPE:  cfg_q.shape  <= pwdata[SHAPE_W-1:0];
				default:    cfg_q.shape  <= cfg_q.shape;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_PERIOD: prdata = 32'(cfg_q.period);
			REG_STEP:   prdata = 32'(cfg_q.step);
			REG_SHAPE:  prdata = 32'(cfg_q.shape);
			default:    prdata = '0;
		endcase
	end

	wwg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.phase_clr (phase_clr),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	wwg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	wwg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### tb/sv/wavetable_waveform_generator_test.sv
module wavetable_waveform_generator_test import wwg_pkg::*;;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = 40;
	localparam int RANDOM_TICKS = 1470;
	localparam int STEADY_TICKS = 300;

	typedef struct {
		logic [SAMPLE_W-1:0] level;
		logic [IDX_W-1:0]    pos;
	} wave_point_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;    // [0] tick
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [7:0] sample, [17:8] position
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Shadow of the generator: registers and phase index
	logic [PER_W-1:0]   shadow_period = PERIOD_RST;
	logic [STEP_W-1:0]  shadow_step   = STEP_RST;
	logic [SHAPE_W-1:0] shadow_shape  = SHAPE_RST;
	logic [IDX_W-1:0]   shadow_phase  = '0;

	wave_point_t pending_points[$];
	int          error_count    = 0;
	int          checked_count  = 0;
	int          tick_count     = 0;
	int          dropped_count  = 0;
	int          setting_count  = 0;
	int          cycle_count    = 0;
	int          stall_left     = 0;
	bit          idling_on      = 1'b1;

	wavetable_waveform_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Fixed-point sine level: 24-bit phase, quadrant fold, odd polynomial in Q30
	function automatic logic [SAMPLE_W-1:0] sine_level(input int unsigned idx,
			input int unsigned per);
		logic [63:0] ph, r, x, t, t2, acc, s, one;
		logic [1:0]  quad;
		one  = 64'(Q30_ONE);
		ph   = (64'(idx) << PH_W) / 64'(per);
		quad = ph[23:22];
		r    = ph & 64'h3F_FFFF;
		x    = quad[0] ? (64'h40_0000 - r) : r;
		t    = x << 8;
		t2   = (t * t) >> 30;
		acc  = 64'(SIN_C9);
		acc  = 64'(SIN_C7) - ((t2 * acc) >> 30);
		acc  = 64'(SIN_C5) - ((t2 * acc) >> 30);
		acc  = 64'(SIN_C3) - ((t2 * acc) >> 30);
		acc  = 64'(SIN_C1) - ((t2 * acc) >> 30);
		s    = (t * acc) >> 30;
		if (s > one) s = one;
		if (!quad[1])
			return SAMPLE_W'((64'd255 * (one + s)) >> 31);
		return SAMPLE_W'((64'd255 * (one - s)) >> 31);
	endfunction

	function automatic logic [SAMPLE_W-1:0] wave_level(input int unsigned idx,
			input int unsigned per, input logic [SHAPE_W-1:0] shape);
		int unsigned k;
		case (shape)
			SHAPE_SQUARE:   return (idx < per / 2) ? 8'd0 : 8'd255;
			SHAPE_SINE:     return sine_level(idx, per);
			SHAPE_SAW_UP:   return SAMPLE_W'((256 * idx) / per);
			SHAPE_SAW_DOWN: return SAMPLE_W'(255 - (256 * idx) / per);
			SHAPE_TRIANGLE: begin
				k = (511 * idx) / per;
				return SAMPLE_W'((k <= 255) ? (255 - k) : (k - 255));
			end
			default:        return 8'd127;
		endcase
	endfunction

	// Take one sample at the shadow index and advance it
	task automatic predict_tick();
		int unsigned per, stp, idx;
		wave_point_t pt;
		per = shadow_period;
		if (per < 2) per = 2;
		if (per > MAX_PERIOD) per = MAX_PERIOD;
		idx = shadow_phase;
		if (idx >= per) idx = 0;
		pt.level = wave_level(idx, per, shadow_shape);
		pt.pos   = IDX_W'(idx);
		pending_points.push_back(pt);
		stp = shadow_step;
		if (stp > per) stp = per;
		idx = idx + stp;
		if (idx >= per) idx = idx - per;
		shadow_phase = IDX_W'(idx);
	endtask

	// Offer one item, with an optional idle burst ahead of it
	task automatic send_item(input bit tick);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, tick};
		do @(posedge clk); while (!s_tready);
		if (tick) begin
			tick_count++;
			predict_tick();
		end else begin
			dropped_count++;
		end
	endtask

	// Hold the sender until every expected sample has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_points.size() != 0);
	endtask

	task automatic settle_block();
		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic reg_readback(input logic [1:0] idx, input logic [31:0] expected);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got     = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== expected) begin
			$display("%0t: register %0d readback expected %0h actual %0h",
				$time, idx, expected, got);
			error_count++;
		end
	endtask

	// Write one register; the block must be idle
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PERIOD: begin
				shadow_period = value[PER_W-1:0];
				shadow_phase  = '0;
			end
			REG_STEP:  shadow_step  = value[STEP_W-1:0];
			REG_SHAPE: shadow_shape = value[SHAPE_W-1:0];
			default: ;
		endcase
		case (idx)
			REG_PERIOD: reg_readback(idx, 32'(shadow_period));
			REG_STEP:   reg_readback(idx, 32'(shadow_step));
			default:    reg_readback(idx, 32'(shadow_shape));
		endcase
	endtask

	task automatic apply_settings(input logic [PER_W-1:0] per, input logic [STEP_W-1:0] stp,
			input logic [SHAPE_W-1:0] shape);
		settle_block();
		reg_write(REG_PERIOD, {$urandom} << PER_W | 32'(per));
		reg_write(REG_STEP, {$urandom} << STEP_W | 32'(stp));
		reg_write(REG_SHAPE, {$urandom} << SHAPE_W | 32'(shape));
		setting_count++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(1'b1);
	endtask

	// Reset values and a dropped zero tick
	task automatic test_reset_state();
		reg_readback(REG_PERIOD, 32'(PERIOD_RST));
		reg_readback(REG_STEP, 32'(STEP_RST));
		reg_readback(REG_SHAPE, 32'(SHAPE_RST));
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b1);
		send_item(1'b1);
	endtask

	// Periods below two and above the maximum, zero and oversized steps
	task automatic test_period_limits();
		apply_settings(11'd0, 9'd1, SHAPE_SQUARE);
		send_ticks(3);
		apply_settings(11'd1, 9'd1, SHAPE_SAW_UP);
		send_ticks(2);
		apply_settings(11'd2047, 9'd511, SHAPE_TRIANGLE);
		send_ticks(2);
		apply_settings(11'd1024, 9'd0, SHAPE_SAW_UP);
		send_ticks(2);
	endtask

	// Remaining shapes, including the unused codes
	task automatic test_shape_codes();
		apply_settings(11'd4, 9'd1, SHAPE_SINE);
		send_ticks(4);
		apply_settings(11'd4, 9'd1, SHAPE_SAW_DOWN);
		send_ticks(2);
		apply_settings(11'd4, 9'd1, 3'd6);
		send_item(1'b1);
		apply_settings(11'd4, 9'd1, 3'd7);
		send_item(1'b1);
	endtask

	// Random settings, partial rewrites, idle bursts and drain pauses
	task automatic test_random_settings();
		int                 phase_no;
		int                 n;
		int                 pause_at;
		logic [PER_W-1:0]   per;
		logic [STEP_W-1:0]  stp;
		logic [SHAPE_W-1:0] shape;
		phase_no = 0;
		while (tick_count < RANDOM_TICKS) begin
			case ($urandom_range(0, 9))
				0:       per = PER_W'($urandom_range(0, 2));
				1:       per = PER_W'($urandom_range(1024, 2047));
				2:       per = PER_W'(MAX_PERIOD);
				3:       per = PER_W'($urandom_range(0, 2047));
				default: per = PER_W'($urandom_range(2, 64));
			endcase
			case ($urandom_range(0, 7))
				0:       stp = 9'd0;
				1:       stp = 9'd256;
				2:       stp = STEP_W'($urandom_range(257, 511));
				3:       stp = STEP_W'($urandom_range(1, 256));
				default: stp = STEP_W'($urandom_range(1, 9));
			endcase
			shape = ($urandom_range(0, 9) == 0) ? SHAPE_W'($urandom_range(6, 7))
				: SHAPE_W'($urandom_range(0, 5));
			settle_block();
			// Rewrite a random subset so the index sometimes carries over
			if (phase_no == 0 || $urandom_range(0, 1)) reg_write(REG_PERIOD,
				{$urandom} << PER_W | 32'(per));
			if ($urandom_range(0, 1)) reg_write(REG_STEP, {$urandom} << STEP_W | 32'(stp));
			reg_write(REG_SHAPE, {$urandom} << SHAPE_W | 32'(shape));
			setting_count++;
			n = $urandom_range(10, 70);
			pause_at = (phase_no % 3 == 0) ? $urandom_range(0, n - 1) : -1;
			for (int k = 0; k < n; k++) begin
				if (k == pause_at) wait_drained();
				send_item($urandom_range(0, 9) != 0);
			end
			phase_no++;
		end
	endtask

	// Back-to-back sine ticks with no idling on either side
	task automatic test_steady_stream();
		apply_settings(PER_W'($urandom_range(2, MAX_PERIOD)),
			STEP_W'($urandom_range(1, 40)), SHAPE_SINE);
		idling_on = 1'b0;
		send_ticks(STEADY_TICKS);
	endtask

	// Receiver stalls in short bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result item with the oldest expected sample
	always @(posedge clk) begin
		wave_point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result item sample %0d position %0d",
					$time, m_tdata[7:0], m_tdata[17:8]);
				error_count++;
			end else begin
				want = pending_points.pop_front();
				checked_count++;
				if (m_tdata[7:0] !== want.level) begin
					$display("%0t: sample expected %0d actual %0d (position %0d)",
						$time, want.level, m_tdata[7:0], want.pos);
					error_count++;
				end
				if (m_tdata[17:8] !== want.pos) begin
					$display("%0t: position expected %0d actual %0d",
						$time, want.pos, m_tdata[17:8]);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d samples outstanding", $time,
				pending_points.size());
			$display("wavetable_waveform_generator_test failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_period_limits();
		test_shape_codes();
		test_random_settings();
		test_steady_stream();
		settle_block();
		$display("Covered %0d tick items and %0d zero ticks over %0d register settings,",
			tick_count, dropped_count, setting_count);
		$display("all six shapes, unused codes, period and step clamps; %0d samples checked.",
			checked_count);
		if (error_count == 0) begin
			$display("wavetable_waveform_generator_test passed");
		end else begin
			$display("wavetable_waveform_generator_test failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/wwg_pkg.sv
hw/rtl/wwg_front.sv
hw/rtl/wwg_queue.sv
hw/rtl/wwg_back.sv
hw/rtl/wavetable_waveform_generator.sv
tb/sv/wavetable_waveform_generator_test.sv
